// ===== sv/dpcs_pkg.sv =====
// Shared constants, command codes and the channel command struct of the
// delayed pulse channel scheduler. No dependencies.
package dpcs_pkg;

	// fixed field widths
	localparam int MASK_BITS   = 8;
	localparam int FUNC_W      = 3;
	localparam int CFG_W       = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	// parameter defaults
	localparam int DEFAULT_NUM_CHANNELS = 8;
	localparam int DEFAULT_TIME_BITS    = 32;

	// register reset values
	localparam logic [CFG_W-1:0] RESET_START_DELAY  = 16'd1000;
	localparam logic [CFG_W-1:0] RESET_PULSE_LENGTH = 16'd250;

	// register indexes
	localparam logic CFG_START_DELAY  = 1'b0;
	localparam logic CFG_PULSE_LENGTH = 1'b1;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SCHEDULE   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_ENTER_PROC = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ENTER_DIAG = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DIAG_SET   = 3'd4;

	// decoded command broadcast to every channel
	typedef struct packed {
		logic tick;
		logic schedule;
		logic enter_proc;
		logic enter_diag;
		logic diag_set;
		logic diag_on;
	} chan_cmd_t;

endpackage

// ===== sv/delayed_pulse_channel_scheduler.sv =====
// Top level of the delayed pulse channel scheduler: input register, time
// counter, configuration registers, channel array and result register.
// Depends on dpcs_pkg and dpcs_channel.

// The block takes one command item per clock and returns one result item
// for each, in order. An accepted item is held in the input register. When
// it advances, all channels update in parallel, with two deadline compares
// per channel. The result is read straight from the updated channel state in
// the following cycle and is taken no earlier than the end of that cycle. If
// the output side stalls, the result is held in the result register and the
// input register waits, so the channels do not move on. Sustained rate is one
// item per cycle while the output side is ready. The result holds the
// channels driven on, the active-low pin levels and the channels waiting for
// their switch-on time, all sampled after the item's update. Register writes
// (start delay, pulse length) are taken any cycle but should be made while no
// item is in flight.
module delayed_pulse_channel_scheduler #(
	parameter int NUM_CHANNELS = dpcs_pkg::DEFAULT_NUM_CHANNELS,
	parameter int TIME_BITS    = dpcs_pkg::DEFAULT_TIME_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [dpcs_pkg::CFG_W-1:0]          cfg_wdata,
	// command items
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// func [2:0], channel_mask [10:3], diag_on [11], zeros [15:12]
	input  logic [dpcs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// result items
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// on_mask [7:0], pin_levels [15:8], scheduled_mask [23:16]
	output logic [dpcs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import dpcs_pkg::*;

	localparam int NUM_OUT = (NUM_CHANNELS < MASK_BITS) ? NUM_CHANNELS : MASK_BITS;

	// configuration registers
	logic [CFG_W-1:0] start_delay_q, pulse_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q  <= RESET_START_DELAY;
			pulse_length_q <= RESET_PULSE_LENGTH;
		end else if (cfg_we) begin
			if (cfg_index == CFG_START_DELAY)
				start_delay_q <= cfg_wdata;
			else
				pulse_length_q <= cfg_wdata;
		end
	end

	// input register
	logic                valid_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic [MASK_BITS-1:0] mask_s1;
	logic                diag_on_s1;
	logic                adv;

	assign adv           = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1    <= s_axis_tdata[FUNC_W-1:0];
			mask_s1    <= s_axis_tdata[FUNC_W +: MASK_BITS];
			diag_on_s1 <= s_axis_tdata[FUNC_W+MASK_BITS];
		end
	end

	// command decode
	chan_cmd_t cmd;

	always_comb begin
		cmd         = '0;
		cmd.diag_on = diag_on_s1;
		unique case (func_s1)
			FUNC_TICK:       cmd.tick       = 1'b1;
			FUNC_SCHEDULE:   cmd.schedule   = 1'b1;
			FUNC_ENTER_PROC: cmd.enter_proc = 1'b1;
			FUNC_ENTER_DIAG: cmd.enter_diag = 1'b1;
			FUNC_DIAG_SET:   cmd.diag_set   = 1'b1;
			default:         cmd.diag_on    = diag_on_s1;
		endcase
	end

	// time counter and shared deadline sums
	logic [TIME_BITS-1:0] now_q, now_tick, on_time, off_time;

	assign now_tick = now_q + {{(TIME_BITS-1){1'b0}}, 1'b1};
	assign on_time  = now_q + {{(TIME_BITS-CFG_W){1'b0}}, start_delay_q};
	assign off_time = on_time + {{(TIME_BITS-CFG_W){1'b0}}, pulse_length_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (adv && cmd.tick) begin
			now_q <= now_tick;
		end
	end

	// channel array
	logic [NUM_CHANNELS-1:0] ch_on, ch_sched;

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
		logic sel;
		if (i < MASK_BITS) begin : g_sel
			assign sel = mask_s1[i];
		end else begin : g_nosel
			assign sel = 1'b0;
		end

		dpcs_channel #(
			.TIME_BITS (TIME_BITS)
		) u_ch (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.cmd      (cmd),
			.sel      (sel),
			.now_cur  (now_q),
			.now_tick (now_tick),
			.on_time  (on_time),
			.off_time (off_time),
			.is_on    (ch_on[i]),
			.is_sched (ch_sched[i])
		);
	end

	// result masks from the updated channel state
	logic [MASK_BITS-1:0] on_vec, sched_vec;

	always_comb begin
		on_vec    = '0;
		sched_vec = '0;
		for (int i = 0; i < NUM_OUT; i++) begin
			on_vec[i]    = ch_on[i];
			sched_vec[i] = ch_sched[i];
		end
	end

	// result register, loaded when the direct result is not taken
	logic                 pend_s2;
	logic                 m_valid_s2;
	logic [MASK_BITS-1:0] on_s2, sched_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= 1'b0;
		end else begin
			pend_s2 <= adv;
		end
	end

	// the update lands on the edge of adv; masks are sampled the cycle after
	logic out_load;
	assign out_load = pend_s2 && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s2 <= 1'b0;
		end else if (out_load) begin
			m_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			on_s2    <= on_vec;
			sched_s2 <= sched_vec;
		end
	end

	assign m_axis_tvalid = m_valid_s2 || pend_s2;
	assign m_axis_tdata  = pend_s2 ? {sched_vec, ~on_vec, on_vec}
	                               : {sched_s2, ~on_s2, on_s2};

	// checks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result side");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd.tick) |=> (now_q == $past(now_tick)))
		else $error("time counter missed a tick");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid)
		else $error("processed item produced no result");

	a_pins_inverse: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:8] == ~m_axis_tdata[7:0]))
		else $error("pin levels not the inverse of on mask");

endmodule

// ===== sv/dpcs_channel.sv =====
// One output channel: mode state machine, driven level and both deadlines.
// Depends on dpcs_pkg.
module dpcs_channel #(
	parameter int TIME_BITS = dpcs_pkg::DEFAULT_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,        // item processed this cycle
	input  dpcs_pkg::chan_cmd_t  cmd,
	input  logic                 sel,       // channel picked by the mask
	input  logic [TIME_BITS-1:0] now_cur,
	input  logic [TIME_BITS-1:0] now_tick,  // time after this tick
	input  logic [TIME_BITS-1:0] on_time,
	input  logic [TIME_BITS-1:0] off_time,
	output logic                 is_on,
	output logic                 is_sched
);
	import dpcs_pkg::*;

	localparam logic [2:0] MODE_UNSET    = 3'd0;
	localparam logic [2:0] MODE_PROC_OFF = 3'd1;
	localparam logic [2:0] MODE_SCHED    = 3'd2;
	localparam logic [2:0] MODE_PROC_ON  = 3'd3;
	localparam logic [2:0] MODE_DIAG_OFF = 3'd4;
	localparam logic [2:0] MODE_DIAG_ON  = 3'd5;

	logic [2:0]           mode_q, mode_d;
	logic                 on_q, on_d;
	logic [TIME_BITS-1:0] on_dl_q, on_dl_d;
	logic [TIME_BITS-1:0] off_dl_q, off_dl_d;
	logic [TIME_BITS-1:0] on_diff, off_diff;
	logic                 on_reached, off_reached;

	// wraparound-safe deadline checks against the advanced time
	assign on_diff     = now_tick - on_dl_q;
	assign off_diff    = now_tick - off_dl_q;
	assign on_reached  = !on_diff[TIME_BITS-1];
	assign off_reached = !off_diff[TIME_BITS-1];

	// next state per command
	always_comb begin
		mode_d   = mode_q;
		on_d     = on_q;
		on_dl_d  = on_dl_q;
		off_dl_d = off_dl_q;
		if (cmd.tick) begin
			if (mode_q == MODE_SCHED && on_reached) begin
				mode_d = MODE_PROC_ON;
				on_d   = 1'b1;
			end else if (mode_q == MODE_PROC_ON && off_reached) begin
				mode_d = MODE_PROC_OFF;
				on_d   = 1'b0;
			end
		end else if (cmd.schedule) begin
			if (sel) begin
				if (mode_q != MODE_SCHED)
					on_dl_d = on_time;
				off_dl_d = off_time;
				mode_d   = MODE_SCHED;
			end
		end else if (cmd.enter_proc || cmd.enter_diag) begin
			on_dl_d  = now_cur;
			off_dl_d = now_cur;
			mode_d   = cmd.enter_proc ? MODE_PROC_OFF : MODE_DIAG_OFF;
			on_d     = 1'b0;
		end else if (cmd.diag_set) begin
			if (sel) begin
				on_dl_d  = now_cur;
				off_dl_d = now_cur;
				mode_d   = cmd.diag_on ? MODE_DIAG_ON : MODE_DIAG_OFF;
				on_d     = cmd.diag_on;
			end
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_UNSET;
			on_q     <= 1'b0;
			on_dl_q  <= '0;
			off_dl_q <= '0;
		end else if (en) begin
			mode_q   <= mode_d;
			on_q     <= on_d;
			on_dl_q  <= on_dl_d;
			off_dl_q <= off_dl_d;
		end
	end

	assign is_on    = on_q;
	assign is_sched = (mode_q == MODE_SCHED);

endmodule
